### rtl/core/spe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spe_pkg;

  localparam int CORNER_W        = 5;
  localparam int KIND_W          = 2;
  localparam int COUNT_W         = 32;
  localparam int MAX_CORNERS_DEF = 31;
  localparam int STACK_DEPTH     = 32;
  localparam int STACK_AW        = $clog2(STACK_DEPTH);

  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
  } in_beat_t;

  typedef struct packed {
    logic [CORNER_W-1:0] corner;
    logic                end_of_route;
    logic                exhausted;
    logic [COUNT_W-1:0]  route_number;
  } out_beat_t;

  // one level of the search: corner on the route and next neighbor to try
  typedef struct packed {
    logic [CORNER_W-1:0] corner;
    logic [CORNER_W:0]   resume;
  } stack_entry_t;

endpackage
`default_nettype wire

### rtl/core/spe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module spe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/simple_path_enumerator.sv
`timescale 1ns / 1ps
`default_nettype none
// Enumerates simple paths from corner 1 to the target corner in lexicographic
// order. Clear and add-edge beats are applied in the idle state. A next-route
// request runs a backtracking search with a single neighbor-test unit that
// examines the candidate corners in turn (a hit pushes that corner in the same
// cycle); a backtrack passes through S_POP (the stack lives in a RAM with
// registered read). A found route then streams out one corner per cycle; an
// exhausted answer appears the cycle after the deciding step. busy is high from
// the cycle after a request is accepted until the last beat is registered, and
// stays low for a request that is answered exhausted at once. Results are
// strobed for one cycle each and cannot be stalled.
module simple_path_enumerator #(
  parameter int MAX_CORNERS = spe_pkg::MAX_CORNERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire spe_pkg::in_beat_t             in_beat,
  output logic                               out_strobe,
  output spe_pkg::out_beat_t                 out_beat,
  input  wire logic                          cfg_we,
  input  wire logic [spe_pkg::CORNER_W-1:0]  cfg_wdata
);

  import spe_pkg::*;

  localparam int CORNER_TOP = (1 << CORNER_W) - 1;
  localparam int CORNER_CAP = (MAX_CORNERS < CORNER_TOP) ? MAX_CORNERS : CORNER_TOP;
  localparam int ADJ_N      = CORNER_CAP + 1;
  localparam int ADJ_IW     = $clog2(ADJ_N);
  localparam int ENTRY_W    = $bits(stack_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_EMIT,
    S_LAST
  } state_t;

  typedef enum logic [1:0] {
    SS_NOT_STARTED,
    SS_RUNNING,
    SS_DONE
  } search_t;

  state_t                state_r, state_nxt;
  search_t               search_r, search_nxt;
  logic [ADJ_N-1:0]      adj_r [ADJ_N];
  logic [ADJ_N-1:0]      adj_nxt [ADJ_N];
  logic [ADJ_N-1:0]      on_route_r, on_route_nxt;
  logic [CORNER_W-1:0]   highest_r, highest_nxt;
  logic [CORNER_W-1:0]   target_r, target_nxt;
  logic [CORNER_W-1:0]   cur_r, cur_nxt;
  logic [CORNER_W:0]     res_r, res_nxt;
  logic [STACK_AW-1:0]   lvl_r, lvl_nxt;
  logic [STACK_AW-1:0]   emit_k_r, emit_k_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic                  emit_rd_r, emit_rd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_beat_r, out_beat_nxt;

  logic                  ram_we;
  logic [STACK_AW-1:0]   ram_waddr, ram_raddr;
  stack_entry_t          ram_wentry, ram_rentry;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic [ADJ_IW-1:0]     cur_i, res_i, a_i, b_i;
  logic                  in_range, hit, edge_ok;
  logic                  do_exh, do_pop, do_emit;

  assign cur_i      = cur_r[ADJ_IW-1:0];
  assign res_i      = res_r[ADJ_IW-1:0];
  assign a_i        = in_beat.corner_a[ADJ_IW-1:0];
  assign b_i        = in_beat.corner_b[ADJ_IW-1:0];
  assign in_range   = res_r <= {1'b0, highest_r};
  assign hit        = in_range && adj_r[cur_i][res_i] && !on_route_r[res_i];
  assign edge_ok    = (in_beat.corner_a != '0) && (in_beat.corner_b != '0) &&
                      (in_beat.corner_a <= CORNER_W'(CORNER_CAP)) &&
                      (in_beat.corner_b <= CORNER_W'(CORNER_CAP));
  assign ram_rentry = stack_entry_t'(ram_rdata);

  spe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENTRY_W'(ram_wentry)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    search_nxt    = search_r;
    adj_nxt       = adj_r;
    on_route_nxt  = on_route_r;
    highest_nxt   = highest_r;
    target_nxt    = cfg_we ? cfg_wdata : target_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    lvl_nxt       = lvl_r;
    emit_k_nxt    = emit_k_r;
    count_nxt     = count_r;
    emit_rd_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_beat_nxt  = out_beat_r;
    ram_we        = 1'b0;
    ram_waddr     = lvl_r;
    ram_wentry    = '{corner: cur_r, resume: res_r + 1'b1};
    ram_raddr     = lvl_r - 1'b1;
    do_exh        = 1'b0;
    do_pop        = 1'b0;
    do_emit       = 1'b0;

    // stack read issued last cycle lands on the result port now
    if (emit_rd_r) begin
      out_valid_nxt = 1'b1;
      out_beat_nxt  = '{corner: ram_rentry.corner, end_of_route: 1'b0,
                        exhausted: 1'b0, route_number: count_r};
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_beat.kind)
            KIND_CLEAR: begin
              adj_nxt      = '{default: '0};
              on_route_nxt = '0;
              highest_nxt  = '0;
              lvl_nxt      = '0;
              count_nxt    = '0;
              search_nxt   = SS_NOT_STARTED;
            end
            KIND_ADD: begin
              if (edge_ok) begin
                adj_nxt[a_i][b_i] = 1'b1;
                adj_nxt[b_i][a_i] = 1'b1;
                if (in_beat.corner_a > highest_nxt) highest_nxt = in_beat.corner_a;
                if (in_beat.corner_b > highest_nxt) highest_nxt = in_beat.corner_b;
              end
            end
            KIND_REQUEST: begin
              case (search_r)
                SS_DONE: do_exh = 1'b1;
                SS_NOT_STARTED: begin
                  lvl_nxt      = '0;
                  cur_nxt      = CORNER_W'(1);
                  res_nxt      = (CORNER_W+1)'(1);
                  on_route_nxt = ADJ_N'(2);
                  if (target_r == CORNER_W'(1)) begin
                    do_emit = 1'b1;
                  end else begin
                    state_nxt = S_SCAN;
                  end
                end
                default: begin
                  if (lvl_r == '0) begin
                    do_exh = 1'b1;
                  end else begin
                    do_pop = 1'b1;
                  end
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (hit && (lvl_r != STACK_AW'(STACK_DEPTH - 1))) begin
          ram_we              = 1'b1;
          cur_nxt             = res_r[CORNER_W-1:0];
          res_nxt             = (CORNER_W+1)'(1);
          lvl_nxt             = lvl_r + 1'b1;
          on_route_nxt[res_i] = 1'b1;
          if (res_r == {1'b0, target_r}) do_emit = 1'b1;
        end else if (in_range && !hit) begin
          res_nxt = res_r + 1'b1;
        end else if (lvl_r == '0) begin
          do_exh = 1'b1;
        end else begin
          do_pop = 1'b1;
        end
      end
      S_POP: begin
        cur_nxt   = ram_rentry.corner;
        res_nxt   = ram_rentry.resume;
        state_nxt = S_SCAN;
      end
      S_EMIT: begin
        if (emit_k_r != lvl_r) begin
          ram_raddr   = emit_k_r;
          emit_rd_nxt = 1'b1;
          emit_k_nxt  = emit_k_r + 1'b1;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        out_valid_nxt = 1'b1;
        out_beat_nxt  = '{corner: cur_r, end_of_route: 1'b1,
                          exhausted: 1'b0, route_number: count_r};
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_exh) begin
      out_valid_nxt = 1'b1;
      out_beat_nxt  = '{corner: '0, end_of_route: 1'b0,
                        exhausted: 1'b1, route_number: count_r};
      search_nxt    = SS_DONE;
      state_nxt     = S_IDLE;
    end
    if (do_pop) begin
      on_route_nxt[cur_i] = 1'b0;
      lvl_nxt             = lvl_r - 1'b1;
      state_nxt           = S_POP;
    end
    if (do_emit) begin
      count_nxt  = (count_r == '1) ? count_r : count_r + 1'b1;
      search_nxt = SS_RUNNING;
      emit_k_nxt = '0;
      state_nxt  = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      search_r    <= SS_NOT_STARTED;
      adj_r       <= '{default: '0};
      on_route_r  <= '0;
      highest_r   <= '0;
      target_r    <= CORNER_W'(1);
      lvl_r       <= '0;
      count_r     <= '0;
      emit_rd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      search_r    <= search_nxt;
      adj_r       <= adj_nxt;
      on_route_r  <= on_route_nxt;
      highest_r   <= highest_nxt;
      target_r    <= target_nxt;
      lvl_r       <= lvl_nxt;
      count_r     <= count_nxt;
      emit_rd_r   <= emit_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    res_r      <= res_nxt;
    emit_k_r   <= emit_k_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_valid_r;
  assign out_beat   = out_beat_r;

endmodule
`default_nettype wire
